// File: rtl/ps2q_pkg.sv
// Package: shared codes, event layout and control/status structs for the PS/2 event queue.
package ps2q_pkg;

  // Input word kinds
  typedef enum logic [1:0] {
    KIND_KEY   = 2'd0,
    KIND_MOUSE = 2'd1,
    KIND_POLL  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  // Result status codes
  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_EVENT = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_t;

  // Event types
  typedef enum logic [1:0] {
    EV_PRESS   = 2'd0,
    EV_RELEASE = 2'd1,
    EV_MOVE    = 2'd2
  } ev_type_t;

  // Mouse packet byte position
  typedef enum logic [1:0] {
    MP_HEADER = 2'd0,
    MP_DX     = 2'd1,
    MP_DY     = 2'd2
  } mouse_phase_t;

  // Packed queue entry: type, keycode, dx, dy (25 bits)
  typedef struct packed {
    logic [1:0]        ev_type;
    logic [6:0]        code;
    logic signed [7:0] dx;
    logic signed [7:0] dy;
  } event_t;

  localparam int unsigned EVENT_W = $bits(event_t);

  // Release flag and keycode mask of a keyboard byte
  localparam logic [7:0] REL_BIT   = 8'h80;
  localparam logic [7:0] CODE_MASK = 8'h7F;

  // Controller states
  typedef enum logic {
    CS_IDLE,
    CS_LOAD
  } ctl_state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic take_item;    // execute the accepted input word
    logic load_result;  // move the pending result into the output register
  } ps2q_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic out_free;     // output register empty or draining this cycle
  } ps2q_stat_t;

endpackage

// File: rtl/ps2_input_event_queue.sv
// Top level: PS/2 keyboard/mouse event queue with overwrite-oldest ring storage.
//
//   channel  | handshake            | words
//   ---------+----------------------+-----------------------------------------------
//   input    | in_valid / in_ready  | kind, data
//   output   | out_valid / out_ready| status, dropped_oldest, event_type, keycode,
//            |                      | move_x, move_y
//
// Each word is handled as an accept (memory write or read issued, pointers
// updated) and then a load into the output register, a step of its own due to
// the synchronous read port of the event memory. A new word is accepted while
// the previous result still waits in the output register; the load waits when
// that register is occupied. Reset clears pointers, fill count, mouse phase and
// out_valid; the event memory is not cleared and needs no clearing pass.
module ps2_input_event_queue #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        kind,
  input  logic [7:0]        data,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        status,
  output logic              dropped_oldest,
  output logic [1:0]        event_type,
  output logic [6:0]        keycode,
  output logic signed [7:0] move_x,
  output logic signed [7:0] move_y
);
  import ps2q_pkg::*;

  ps2q_cmd_t  cmd;
  ps2q_stat_t stat;

  ps2q_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  ps2q_dpath #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .stat           (stat),
    .kind           (kind),
    .data           (data),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .status         (status),
    .dropped_oldest (dropped_oldest),
    .event_type     (event_type),
    .keycode        (keycode),
    .move_x         (move_x),
    .move_y         (move_y)
  );

endmodule

// File: rtl/ps2q_ctrl.sv
// Controller: state machine that sequences accept and result load for the event queue.
module ps2q_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ps2q_pkg::ps2q_stat_t stat,
  output ps2q_pkg::ps2q_cmd_t  cmd
);
  import ps2q_pkg::*;

  ctl_state_t state, state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next      = state;
    in_ready        = 1'b0;
    cmd.take_item   = 1'b0;
    cmd.load_result = 1'b0;
    unique case (state)
      CS_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.take_item = 1'b1;
          state_next    = CS_LOAD;
        end
      end
      CS_LOAD: begin
        if (stat.out_free) begin
          cmd.load_result = 1'b1;
          state_next      = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  // Checks
  a_take_only_idle: assert property (@(posedge clk) disable iff (rst)
    cmd.take_item |-> state == CS_IDLE)
    else $error("item taken outside idle");
  a_load_after_take: assert property (@(posedge clk) disable iff (rst)
    cmd.take_item |=> state == CS_LOAD)
    else $error("taken item not followed by load state");
  a_no_double_cmd: assert property (@(posedge clk) disable iff (rst)
    !(cmd.take_item && cmd.load_result))
    else $error("take and load in one cycle");

endmodule

// File: rtl/ps2q_dpath.sv
// Datapath: event ring memory, pointers, mouse assembly and output register.
module ps2q_dpath #(
  parameter int unsigned QUEUE_DEPTH = 256
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ps2q_pkg::ps2q_cmd_t  cmd,
  output ps2q_pkg::ps2q_stat_t stat,
  input  logic [1:0]           kind,
  input  logic [7:0]           data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           status,
  output logic                 dropped_oldest,
  output logic [1:0]           event_type,
  output logic [6:0]           keycode,
  output logic signed [7:0]    move_x,
  output logic signed [7:0]    move_y
);
  import ps2q_pkg::*;

  localparam int unsigned AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] PTR_LAST = AW'(QUEUE_DEPTH - 1);
  localparam logic [CW-1:0] CNT_FULL = CW'(QUEUE_DEPTH);

  // Event store, undefined until written
  event_t mem [QUEUE_DEPTH];
  event_t rdata;

  logic [AW-1:0] read_pointer, write_pointer;
  logic [CW-1:0] fill_count;
  mouse_phase_t  mouse_phase;
  logic [7:0]    mouse_first_delta;

  // Pending result of the word being executed
  stat_t pend_status;
  logic  pend_dropped;
  logic  pend_deliver;

  kind_t  kind_c;
  logic   push_en;
  logic   pop_en;
  logic   full;
  logic   empty;
  event_t push_ev;

  function automatic logic [AW-1:0] advance(input logic [AW-1:0] p);
    advance = (p == PTR_LAST) ? '0 : p + AW'(1);
  endfunction

  assign kind_c = kind_t'(kind);
  assign full   = (fill_count == CNT_FULL);
  assign empty  = (fill_count == '0);

  // Decode the word into a push or a pop
  always_comb begin
    push_en = 1'b0;
    pop_en  = 1'b0;
    push_ev = '0;
    unique case (kind_c)
      KIND_KEY: begin
        push_en         = cmd.take_item;
        push_ev.ev_type = ((data & REL_BIT) != 8'h00) ? EV_RELEASE : EV_PRESS;
        push_ev.code    = 7'(data & CODE_MASK);
      end
      KIND_MOUSE: begin
        push_en         = cmd.take_item && (mouse_phase == MP_DY);
        push_ev.ev_type = EV_MOVE;
        push_ev.dx      = mouse_first_delta;
        push_ev.dy      = data;
      end
      KIND_POLL:  pop_en = cmd.take_item && !empty;
      KIND_CLEAR: ;
      default: ;
    endcase
  end

  // Memory write and registered read
  always_ff @(posedge clk) begin
    if (push_en) begin
      mem[write_pointer] <= push_ev;
    end
    if (pop_en) begin
      rdata <= mem[read_pointer];
    end
  end

  // Pointers, fill count and mouse assembly
  always_ff @(posedge clk) begin
    if (rst) begin
      read_pointer      <= '0;
      write_pointer     <= '0;
      fill_count        <= '0;
      mouse_phase       <= MP_HEADER;
      mouse_first_delta <= '0;
    end else if (cmd.take_item) begin
      if (kind_c == KIND_MOUSE) begin
        unique case (mouse_phase)
          MP_HEADER: mouse_phase <= MP_DX;
          MP_DX: begin
            mouse_first_delta <= data;
            mouse_phase       <= MP_DY;
          end
          default: mouse_phase <= MP_HEADER;
        endcase
      end
      if (kind_c == KIND_CLEAR) begin
        read_pointer  <= '0;
        write_pointer <= '0;
        fill_count    <= '0;
      end else if (push_en) begin
        write_pointer <= advance(write_pointer);
        if (full) begin
          read_pointer <= advance(read_pointer);
        end else begin
          fill_count <= fill_count + CW'(1);
        end
      end else if (pop_en) begin
        read_pointer <= advance(read_pointer);
        fill_count   <= fill_count - CW'(1);
      end
    end
  end

  // Pending result
  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      pend_dropped <= push_en && full;
      pend_deliver <= pop_en;
      if (pop_en) begin
        pend_status <= STAT_EVENT;
      end else if (kind_c == KIND_POLL) begin
        pend_status <= STAT_EMPTY;
      end else begin
        pend_status <= STAT_OK;
      end
    end
  end

  // Output register
  assign stat.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_result) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_result) begin
      status         <= pend_status;
      dropped_oldest <= pend_dropped;
      event_type     <= pend_deliver ? rdata.ev_type : 2'd0;
      keycode        <= pend_deliver ? rdata.code : 7'd0;
      move_x         <= pend_deliver ? rdata.dx : 8'sd0;
      move_y         <= pend_deliver ? rdata.dy : 8'sd0;
    end
  end

  // Checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= CNT_FULL)
    else $error("fill count above queue depth");
  a_clear_empties: assert property (@(posedge clk) disable iff (rst)
    cmd.take_item && kind_c == KIND_CLEAR |=> fill_count == '0)
    else $error("clear left entries");
  a_full_holds: assert property (@(posedge clk) disable iff (rst)
    push_en && full |=> full)
    else $error("push into full queue changed fill count");
  a_load_sets_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.load_result |=> out_valid)
    else $error("loaded result not presented");

endmodule

// File: test/ps2_input_event_queue_tb.sv
// Testbench for ps2_input_event_queue: random and directed words checked against a queue predictor.
`timescale 1ns / 1ps

module ps2_input_event_queue_tb;
  import ps2q_pkg::*;

  localparam int unsigned QDEPTH     = 256;
  localparam int unsigned HOLD_CYCLES = 600;
  localparam int unsigned DRAIN_LIMIT = 2000;
  localparam int unsigned MAX_REPORTS = 10;

  // One input word as offered to the block
  typedef struct packed {
    kind_t      w_kind;
    logic [7:0] w_data;
  } in_word_t;

  // One expected result word
  typedef struct {
    stat_t             status;
    logic              dropped;
    ev_type_t          etype;
    logic [6:0]        code;
    logic signed [7:0] mx;
    logic signed [7:0] my;
  } result_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  kind_t             kind = KIND_KEY;
  logic [7:0]        data = 8'h00;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [1:0]        status;
  logic              dropped_oldest;
  logic [1:0]        event_type;
  logic [6:0]        keycode;
  logic signed [7:0] move_x;
  logic signed [7:0] move_y;

  in_word_t pending_words[$];
  result_t  expected_results[$];

  // Traffic shaping, changed only at the falling edge
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  logic        hold_off = 1'b0;

  int unsigned fault_count = 0;

  // Predicted queue state
  event_t       shadow_store[QDEPTH];
  int unsigned  shadow_rd = 0;
  int unsigned  shadow_wr = 0;
  int unsigned  shadow_fill = 0;
  mouse_phase_t shadow_phase = MP_HEADER;
  logic [7:0]   shadow_dx = 8'h00;

  // Run statistics
  int unsigned n_words = 0;
  int unsigned n_delivered = 0;
  int unsigned n_drops = 0;
  int unsigned n_empty = 0;
  int unsigned n_clears = 0;
  int unsigned peak_fill = 0;

  ps2_input_event_queue #(
    .QUEUE_DEPTH(QDEPTH)
  ) DUT (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .kind          (kind),
    .data          (data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .status        (status),
    .dropped_oldest(dropped_oldest),
    .event_type    (event_type),
    .keycode       (keycode),
    .move_x        (move_x),
    .move_y        (move_y)
  );

  always #5 clk = ~clk;

  // Push into the shadow ring; returns 1 when the oldest entry was overwritten
  function automatic logic shadow_push(input event_t ev);
    logic lost;
    lost = 1'b0;
    if (shadow_fill >= QDEPTH) begin
      shadow_rd = (shadow_rd + 1) % QDEPTH;
      shadow_fill--;
      lost = 1'b1;
      n_drops++;
    end
    shadow_store[shadow_wr] = ev;
    shadow_wr = (shadow_wr + 1) % QDEPTH;
    shadow_fill++;
    if (shadow_fill > peak_fill) peak_fill = shadow_fill;
    return lost;
  endfunction

  // Apply one accepted word to the shadow state and queue its result
  task automatic predict_word(input kind_t k, input logic [7:0] d);
    result_t r;
    event_t  ev;
    r.status  = STAT_OK;
    r.dropped = 1'b0;
    r.etype   = EV_PRESS;
    r.code    = '0;
    r.mx      = '0;
    r.my      = '0;
    ev        = '0;
    case (k)
      KIND_KEY: begin
        ev.ev_type = ((d & REL_BIT) != 0) ? EV_RELEASE : EV_PRESS;
        ev.code    = 7'(d & CODE_MASK);
        r.dropped  = shadow_push(ev);
      end
      KIND_MOUSE: begin
        case (shadow_phase)
          MP_HEADER: shadow_phase = MP_DX;
          MP_DX: begin
            shadow_dx    = d;
            shadow_phase = MP_DY;
          end
          default: begin
            shadow_phase = MP_HEADER;
            ev.ev_type   = EV_MOVE;
            ev.dx        = shadow_dx;
            ev.dy        = d;
            r.dropped    = shadow_push(ev);
          end
        endcase
      end
      KIND_POLL: begin
        if (shadow_fill == 0) begin
          r.status = STAT_EMPTY;
          n_empty++;
        end else begin
          ev = shadow_store[shadow_rd];
          shadow_rd = (shadow_rd + 1) % QDEPTH;
          shadow_fill--;
          r.status = STAT_EVENT;
          r.etype  = ev_type_t'(ev.ev_type);
          r.code   = ev.code;
          r.mx     = ev.dx;
          r.my     = ev.dy;
          n_delivered++;
        end
      end
      default: begin
        // clear keeps the mouse grouping
        shadow_rd   = 0;
        shadow_wr   = 0;
        shadow_fill = 0;
        n_clears++;
      end
    endcase
    n_words++;
    expected_results.push_back(r);
  endtask

  // Driver: offers the next pending word, with random gaps
  always @(posedge clk) begin
    in_word_t w;
    if (rst) begin
      in_valid <= 1'b0;
      kind     <= KIND_KEY;
      data     <= 8'h00;
    end else begin
      if (in_valid && in_ready) predict_word(kind, data);
      if (!in_valid || in_ready) begin
        if (pending_words.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          w = pending_words.pop_front();
          in_valid <= 1'b1;
          kind     <= w.w_kind;
          data     <= w.w_data;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks each accepted result against the oldest expectation
  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_results.size() == 0) begin
          fault_count++;
          if (fault_count <= MAX_REPORTS)
            $display("[%0t] unexpected result word: status=%0d drop=%0b type=%0d code=%0h",
                     $realtime, status, dropped_oldest, event_type, keycode);
        end else begin
          want = expected_results.pop_front();
          if (status !== want.status || dropped_oldest !== want.dropped ||
              event_type !== want.etype || keycode !== want.code ||
              move_x !== want.mx || move_y !== want.my) begin
            fault_count++;
            if (fault_count <= MAX_REPORTS) begin
              $display("[%0t] mismatch exp: status=%0d drop=%0b type=%0d code=%02h dx=%0d dy=%0d",
                       $realtime, want.status, want.dropped, want.etype, want.code,
                       want.mx, want.my);
              $display("[%0t]          got: status=%0d drop=%0b type=%0d code=%02h dx=%0d dy=%0d",
                       $realtime, status, dropped_oldest, event_type, keycode,
                       move_x, move_y);
            end
          end
        end
      end
      out_ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end
  end

  function automatic void add_word(input kind_t k, input logic [7:0] d);
    in_word_t w;
    w.w_kind = k;
    w.w_data = d;
    pending_words.push_back(w);
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(255));
  endfunction

  // Mostly whole key bytes, mouse packets and polls; a few clears and stray mouse bytes
  task automatic add_random_traffic(input int unsigned n);
    int unsigned added;
    int unsigned pick;
    added = 0;
    while (added < n) begin
      pick = $urandom_range(99);
      if (pick < 38) begin
        add_word(KIND_KEY, rand_byte());
        added += 1;
      end else if (pick < 60) begin
        repeat (3) add_word(KIND_MOUSE, rand_byte());
        added += 3;
      end else if (pick < 93) begin
        add_word(KIND_POLL, rand_byte());
        added += 1;
      end else if (pick < 96) begin
        add_word(KIND_CLEAR, rand_byte());
        added += 1;
      end else begin
        add_word(KIND_MOUSE, rand_byte());
        added += 1;
      end
    end
  endtask

  // Pushes only, enough to wrap the ring past full
  task automatic add_push_burst(input int unsigned n_events);
    repeat (n_events) begin
      if ($urandom_range(99) < 85) add_word(KIND_KEY, rand_byte());
      else repeat (3) add_word(KIND_MOUSE, rand_byte());
    end
  endtask

  task automatic wait_sent();
    while (pending_words.size() != 0 || in_valid) @(negedge clk);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty poll, clear on empty queue, key extremes, signed move extremes
    add_word(KIND_POLL, 8'h00);
    add_word(KIND_CLEAR, 8'hFF);
    add_word(KIND_KEY, 8'h00);
    add_word(KIND_KEY, 8'h7F);
    add_word(KIND_KEY, 8'h80);
    add_word(KIND_KEY, 8'hFF);
    add_word(KIND_MOUSE, 8'hFF);
    add_word(KIND_MOUSE, 8'h80);
    add_word(KIND_MOUSE, 8'h7F);
    add_word(KIND_MOUSE, 8'h00);
    add_word(KIND_MOUSE, 8'h7F);
    add_word(KIND_MOUSE, 8'h80);
    repeat (6) add_word(KIND_POLL, 8'hAA);
    // Clear with an event queued in the middle of a mouse packet
    add_word(KIND_MOUSE, 8'h08);
    add_word(KIND_MOUSE, 8'h01);
    add_word(KIND_KEY, 8'h2A);
    add_word(KIND_CLEAR, 8'h00);
    add_word(KIND_MOUSE, 8'hFE);
    add_word(KIND_POLL, 8'hFF);
    add_word(KIND_POLL, 8'h55);
    wait_sent();

    // Random phases with different idling
    add_random_traffic(140);
    wait_sent();
    @(negedge clk);
    send_idle_pct = 54;
    add_random_traffic(140);
    wait_sent();
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 54;
    add_random_traffic(140);
    wait_sent();
    @(negedge clk);
    send_idle_pct  = 24;
    recv_stall_pct = 24;
    add_random_traffic(100);
    wait_sent();

    // Long receiver hold-off that stalls the pushes, then overflow and drain
    @(negedge clk);
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off       = 1'b1;
    add_push_burst(280);
    repeat (HOLD_CYCLES) @(negedge clk);
    hold_off = 1'b0;
    repeat (150) add_word(KIND_POLL, rand_byte());
    wait_sent();

    for (int i = 0; i < DRAIN_LIMIT && expected_results.size() != 0; i++) @(negedge clk);
    repeat (8) @(negedge clk);
    if (expected_results.size() != 0) begin
      fault_count++;
      $display("%0d expected result words never arrived", expected_results.size());
    end

    $display("Covered %0d words: %0d events delivered, %0d empty polls, %0d clears,",
             n_words, n_delivered, n_empty, n_clears);
    $display("  %0d pushes that overwrote the oldest entry, peak fill %0d of %0d; %0d faults",
             n_drops, peak_fill, QDEPTH, fault_count);
    if (fault_count == 0) begin
      $display("** ps2_input_event_queue: PASSED **");
    end else begin
      $display("** ps2_input_event_queue: FAILED **");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("Timeout: run did not complete");
    $display("** ps2_input_event_queue: FAILED **");
    $finish;
  end

endmodule
